FILE: rtl/cts_pkg.sv
// ============================================================================
// cts_pkg: shared types and constants for the calendar to serial date block
// Holds the pipeline stage records, the calendar constants and the table of
// days before each month.
// ============================================================================
`default_nettype none

package cts_pkg;

  // Input field and result field types.
  typedef logic [15:0]        field_t;
  typedef logic signed [22:0] day_num_t;
  typedef logic [16:0]        sod_t;
  typedef logic signed [38:0] serial_t;

  // Narrowed calendar values once the range checks have passed.
  typedef logic [13:0] year_t;
  typedef logic [3:0]  mon_t;
  typedef logic [4:0]  mday_t;

  localparam logic [15:0] YEAR_MAX     = 16'd9999;
  localparam logic [15:0] MONTH_MAX    = 16'd12;
  localparam logic [15:0] MDAY_MAX     = 16'd31;
  localparam logic [15:0] HOUR_MAX     = 16'd23;
  localparam logic [15:0] MINSEC_MAX   = 16'd59;
  localparam logic [23:0] EPOCH_DAYS   = 24'd693959;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [11:0] SECS_PER_HR  = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;
  localparam logic [8:0]  DAYS_PER_YR  = 9'd365;

  // Division of a year (0..9999) by 100 as a multiply by a scaled reciprocal.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [6:0]  HUNDRED      = 7'd100;

  localparam mon_t FEB = 4'd2;

  // Stage 1: range checks done, year split and time of day summed.
  typedef struct packed {
    logic   ok;
    year_t  year;
    mon_t   month;
    mday_t  day;
    logic [6:0]  cent;
    logic [21:0] year_days;
    sod_t   sod;
  } s1_t;

  // Stage 2: full validity and day number.
  typedef struct packed {
    logic     ok;
    day_num_t days;
    sod_t     sod;
  } s2_t;

  // Stage 3: day number scaled to seconds.
  typedef struct packed {
    logic     ok;
    day_num_t days;
    sod_t     sod;
    serial_t  prod;
  } s3_t;

  // Days in the year before the first of the given month.
  function automatic logic [8:0] cum_days(input mon_t m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of the given month.
  function automatic mday_t month_len(input mon_t m, input logic leap);
    mday_t r;
    case (m) inside
      FEB:                       r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cts_in_if.sv
// ============================================================================
// cts_in_if: calendar date and time channel
// Valid/ready channel carrying one calendar date and time of day.
// ============================================================================
`default_nettype none

interface cts_in_if;
  logic            valid;
  logic            ready;
  cts_pkg::field_t year;
  cts_pkg::field_t month;
  cts_pkg::field_t day;
  cts_pkg::field_t hour;
  cts_pkg::field_t minute;
  cts_pkg::field_t second;

  modport source (output valid, year, month, day, hour, minute, second, input ready);
  modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

`default_nettype wire

FILE: rtl/cts_out_if.sv
// ============================================================================
// cts_out_if: serial date result channel
// Valid/ready channel carrying the validity flag, day number and serial time.
// ============================================================================
`default_nettype none

interface cts_out_if;
  logic              valid;
  logic              ready;
  logic              valid_res;
  cts_pkg::day_num_t day_number;
  cts_pkg::sod_t     seconds_of_day;
  cts_pkg::serial_t  serial_seconds;

  modport source (output valid, valid_res, day_number, seconds_of_day, serial_seconds,
                  input ready);
  modport sink   (input valid, valid_res, day_number, seconds_of_day, serial_seconds,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/cts_day_calc.sv
// ============================================================================
// cts_day_calc: leap year rule, day-of-month check and day number
// Combinational logic of the second pipeline stage.
// ============================================================================
`default_nettype none

module cts_day_calc (
  input  cts_pkg::s1_t s1,
  output cts_pkg::s2_t s2
);
  import cts_pkg::*;

  logic [13:0] cent_x100;
  logic        rem_zero;
  logic        leap;
  mday_t       mlen;
  logic        adj;
  logic [23:0] sum;

  always_comb begin
    // The year is a century year exactly when it equals its century times 100.
    cent_x100 = 14'(s1.cent * HUNDRED);
    rem_zero  = (cent_x100 == s1.year);
    leap      = (s1.year[1:0] == 2'd0) && (!rem_zero || (s1.cent[1:0] == 2'd0));
    mlen      = month_len(s1.month, leap);
    adj       = leap && (s1.month <= FEB);

    sum = 24'(s1.year_days) + 24'(s1.year[13:2]) - 24'(s1.cent) + 24'(s1.cent[6:2])
        + 24'(cum_days(s1.month)) + 24'(s1.day) - 24'(adj) - EPOCH_DAYS;

    s2.ok   = s1.ok && (s1.day != 5'd0) && (s1.day <= mlen);
    s2.days = day_num_t'(sum[22:0]);
    s2.sod  = s1.sod;
  end

endmodule

`default_nettype wire

FILE: rtl/calendar_to_serial_date.sv
// ============================================================================
// calendar_to_serial_date: Gregorian date and time to serial day and seconds
// Validates a calendar date and time of day and returns the day number
// counted from 30 December 1899 and the signed serial time in seconds.
// ============================================================================
//
//   Channel  Role    Payload
//   -------  ------  ---------------------------------------------------------
//   in_ch    sink    year, month, day, hour, minute, second (16 bits each)
//   out_ch   source  valid_res, day_number, seconds_of_day, serial_seconds
//
// An accepted transaction passes through the stage registers s1, s2 and s3
// into the result register, and a new one can be accepted in every cycle
// in which the pipeline is not stalled. The four register stages are:
// range checks with the year split and time sum, the leap rule and day number,
// the multiply by 86400, and the final add or subtract of the time of day.
// The whole pipeline advances together; it stalls only when the result
// register holds a transaction that the sink has not taken, so nothing is
// lost or repeated. Reset clears the stage valid bits only.
// ============================================================================
`default_nettype none

module calendar_to_serial_date (
  input  wire logic  clk,
  input  wire logic  rst,
  cts_in_if.sink     in_ch,
  cts_out_if.source  out_ch
);
  import cts_pkg::*;

  // Pipeline advance enable: the result register is empty or being drained.
  logic adv;

  logic v1, v2, v3, v4;
  s1_t  s1_next, s1;
  s2_t  s2_next, s2;
  s3_t  s3;

  logic     res_ok;
  day_num_t res_days;
  sod_t     res_sod;
  serial_t  res_serial;

  // The product of a day number in range and 86400 always fits 39 bits.
  serial_t  prod_full;

  assign adv         = !v4 || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 1: range checks that do not need the leap rule, the century of
  // the year by reciprocal multiply, the year times 365 and the time of day.
  always_comb begin
    logic [26:0] cent_prod;
    cent_prod = 27'(14'(in_ch.year) * DIV100_MUL);

    s1_next.ok = (in_ch.year <= YEAR_MAX)
              && (in_ch.month != 16'd0) && (in_ch.month <= MONTH_MAX)
              && (in_ch.day <= MDAY_MAX)
              && (in_ch.hour <= HOUR_MAX)
              && (in_ch.minute <= MINSEC_MAX)
              && (in_ch.second <= MINSEC_MAX);
    s1_next.year      = year_t'(in_ch.year[13:0]);
    s1_next.month     = mon_t'(in_ch.month[3:0]);
    s1_next.day       = mday_t'(in_ch.day[4:0]);
    s1_next.cent      = cent_prod[DIV100_SHIFT+6:DIV100_SHIFT];
    s1_next.year_days = 22'(in_ch.year[13:0] * DAYS_PER_YR);
    s1_next.sod       = 17'(in_ch.hour[4:0] * SECS_PER_HR)
                      + 17'(in_ch.minute[5:0] * SECS_PER_MIN)
                      + 17'(in_ch.second[5:0]);
  end

  // Stage 2: leap rule, day-of-month check and day number.
  cts_day_calc u_day_calc (
    .s1 (s1),
    .s2 (s2_next)
  );

  // Stage 3 multiply: day number times seconds per day.
  assign prod_full = s2.days * $signed({1'b0, SECS_PER_DAY});

  // Stage 4: the time of day moves the serial value away from day zero.
  // An invalid transaction reports zero in every result field.
  always_comb begin
    res_ok     = s3.ok;
    res_days   = s3.ok ? s3.days : '0;
    res_sod    = s3.ok ? s3.sod : '0;
    res_serial = '0;
    if (s3.ok) begin
      if (s3.days[22]) begin
        res_serial = s3.prod - serial_t'({22'd0, s3.sod});
      end else begin
        res_serial = s3.prod + serial_t'({22'd0, s3.sod});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1                    <= s1_next;
      s2                    <= s2_next;
      s3.ok                 <= s2.ok;
      s3.days               <= s2.days;
      s3.sod                <= s2.sod;
      s3.prod               <= prod_full;
      out_ch.valid_res      <= res_ok;
      out_ch.day_number     <= res_days;
      out_ch.seconds_of_day <= res_sod;
      out_ch.serial_seconds <= res_serial;
    end
  end

  assign out_ch.valid = v4;

  // A rejected transaction carries zero in all result fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.valid_res) |->
      (out_ch.day_number == '0 && out_ch.seconds_of_day == '0 &&
       out_ch.serial_seconds == '0))
    else $error("rejected result has nonzero fields");

  // An accepted result keeps the time of day within one day.
  a_sod_range: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.valid_res) |-> (out_ch.seconds_of_day < SECS_PER_DAY))
    else $error("seconds of day out of range");

  // The serial time has the sign of the day number.
  a_serial_sign: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.valid_res) |->
      (out_ch.serial_seconds[38] == out_ch.day_number[22]))
    else $error("serial time sign differs from day number sign");

  // A transaction in stage three reaches the result register on advance.
  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    (v3 && adv) |=> v4)
    else $error("transaction lost between stage three and the result register");

endmodule

`default_nettype wire
